[rtl/tosd_pkg.sv]
// Shared types, widths and constants for the tracked object speed/distance core.
// Used by tosd_calc, tracked_object_speed_distance_core and the testbench; depends on nothing.
package tosd_pkg;

    // Field widths
    localparam int ID_W    = 8;
    localparam int FRAME_W = 32;
    localparam int POS_W   = 20;
    localparam int DIST_W  = 20;
    localparam int SPEED_W = 24;
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 32;
    localparam int RATE_W  = 16;

    // frame_rate carries 8 fraction bits (frames per second times 256)
    localparam int RATE_FRAC_BITS = 8;
    localparam logic [RATE_W-1:0] FRAME_RATE_RESET = 16'd7680;

    localparam int MAX_OBJECTS_DEFAULT = 256;

    // Arithmetic widths
    localparam int MAG_W    = POS_W;              // |a - b| of two positions
    localparam int ROOT_W   = POS_W + 1;          // unsaturated step distance
    localparam int SQ_W     = 2 * MAG_W;          // one squared difference
    localparam int RAD_W    = SQ_W + 1;           // sum of two squares
    localparam int ROOT_TOP = 2 * ((RAD_W - 1) / 2);
    localparam int PROD_W   = (SQ_W > ROOT_W + RATE_W) ? SQ_W : ROOT_W + RATE_W;
    localparam int NUM_W    = ROOT_W + RATE_W - RATE_FRAC_BITS;  // dividend
    localparam int HEAD_W   = NUM_W - SPEED_W;                   // bits above the quotient
    localparam int CNT_W    = $clog2(SPEED_W);

    typedef struct packed {
        logic [ID_W-1:0]           object_id;
        logic [FRAME_W-1:0]        frame_number;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    result_id;
        logic               first_seen;
        logic [DIST_W-1:0]  step_distance;
        logic [SPEED_W-1:0] speed;
        logic [TOTAL_W-1:0] total_distance;
        logic [COUNT_W-1:0] sightings;
    } out_item_t;

    // One table entry
    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] last_x;
        logic signed [POS_W-1:0] last_y;
        logic [FRAME_W-1:0]      last_frame;
        logic [TOTAL_W-1:0]      running_distance;
        logic [COUNT_W-1:0]      sighting_count;
    } entry_t;

    // Request to the arithmetic sequencer
    typedef struct packed {
        logic [MAG_W-1:0]   dx_mag;
        logic [MAG_W-1:0]   dy_mag;
        logic [FRAME_W-1:0] delta;
        logic               speed_en;
    } calc_req_t;

    // Result from the arithmetic sequencer
    typedef struct packed {
        logic [ROOT_W-1:0]  step;
        logic [SPEED_W-1:0] speed;
    } calc_res_t;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_READ,
        T_PREP,
        T_CALC,
        T_WRITE
    } top_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SQX,
        C_SQY,
        C_SUM,
        C_ROOT,
        C_MUL,
        C_SAT,
        C_DIV,
        C_DONE
    } calc_state_t;

endpackage

[rtl/tracked_object_speed_distance_core.sv]
// Top level of the tracked object speed/distance core: object table, sequencing, I/O.
// Depends on tosd_pkg, tosd_ram and tosd_calc.
//
//  port group  | dir | handshake          | word / content
//  ------------+-----+--------------------+-----------------------------------------
//  cfg         | in  | cfg_we (no wait)   | cfg_data: frame_rate, frames/s times 256
//  in          | in  | in_valid/in_ready  | in_data: object_id, frame, pos_x, pos_y
//  out         | out | out_valid/out_ready| out_data: id, first, step, speed, totals
//
// Sequence: one word at a time, in_ready low until its result is loaded. With the output
// free a first sighting goes accept, read, prepare, write; a later one adds the arithmetic
// sequencer (square/sum, root, multiply, check, divide, done) before the write, which
// skips multiply, check and divide with no speed (frame not later), divide on saturation.
// Reset: a clearing pass marks every entry empty, in_ready low; 30 fps.
// Stalls: a waiting result holds only the table write of the next word, not its accept.
module tracked_object_speed_distance_core #(
    parameter int MAX_OBJECTS = tosd_pkg::MAX_OBJECTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tosd_pkg::RATE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tosd_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tosd_pkg::out_item_t         out_data
);

    localparam int IDX_W   = $clog2(MAX_OBJECTS);
    localparam int ENTRY_W = $bits(tosd_pkg::entry_t);
    localparam int NUM_IDS = 1 << tosd_pkg::ID_W;
    localparam int POS_W   = tosd_pkg::POS_W;
    localparam int MAG_W   = tosd_pkg::MAG_W;
    localparam int FRAME_W = tosd_pkg::FRAME_W;
    localparam int TOTAL_W = tosd_pkg::TOTAL_W;
    localparam int COUNT_W = tosd_pkg::COUNT_W;
    localparam int ROOT_W  = tosd_pkg::ROOT_W;
    localparam int DIST_W  = tosd_pkg::DIST_W;

    // ---------------------------------------------------------------------
    // Id to table slot: id modulo table size, as a constant table
    // ---------------------------------------------------------------------
    logic [IDX_W-1:0] slot_tab [NUM_IDS];

    for (genvar g = 0; g < NUM_IDS; g++)
    begin : g_slot
        assign slot_tab[g] = IDX_W'(g % MAX_OBJECTS);
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    tosd_pkg::top_state_t state_reg, state_next;

    logic [tosd_pkg::RATE_W-1:0] rate_reg;
    logic [IDX_W-1:0]            clr_reg, clr_next;
    logic                        out_valid_reg, out_valid_next;
    tosd_pkg::out_item_t         out_data_reg;
    tosd_pkg::in_item_t          in_reg;
    logic [IDX_W-1:0]            slot_reg;
    tosd_pkg::calc_req_t         req_reg;

    // ---------------------------------------------------------------------
    // Table RAM and control
    // ---------------------------------------------------------------------
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    tosd_pkg::entry_t   rd_ent, new_ent;

    logic                load_out, accept, calc_start, calc_done;
    tosd_pkg::calc_res_t calc_res;
    tosd_pkg::calc_req_t prep_req;
    tosd_pkg::out_item_t out_new;

    assign accept = in_valid && in_ready;
    assign rd_ent = ram_rdata;

    tosd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBJECTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    tosd_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .req   (req_reg),
        .rate  (rate_reg),
        .done  (calc_done),
        .res   (calc_res)
    );

    // ---------------------------------------------------------------------
    // Prepare: differences against the stored entry
    // ---------------------------------------------------------------------
    logic [POS_W:0]   dx_diff, dy_diff, dx_neg, dy_neg;
    logic [FRAME_W:0] delta_diff;

    always_comb
    begin
        dx_diff = {in_reg.pos_x[POS_W-1], in_reg.pos_x}
                - {rd_ent.last_x[POS_W-1], rd_ent.last_x};
        dy_diff = {in_reg.pos_y[POS_W-1], in_reg.pos_y}
                - {rd_ent.last_y[POS_W-1], rd_ent.last_y};
        dx_neg  = -dx_diff;
        dy_neg  = -dy_diff;
        delta_diff = {1'b0, in_reg.frame_number} - {1'b0, rd_ent.last_frame};

        // magnitudes fit MAG_W bits unsigned
        prep_req.dx_mag   = dx_diff[POS_W] ? dx_neg[MAG_W-1:0] : dx_diff[MAG_W-1:0];
        prep_req.dy_mag   = dy_diff[POS_W] ? dy_neg[MAG_W-1:0] : dy_diff[MAG_W-1:0];
        prep_req.delta    = delta_diff[FRAME_W-1:0];
        // speed only when the new frame is strictly later
        prep_req.speed_en = !delta_diff[FRAME_W] && (delta_diff[FRAME_W-1:0] != '0);
    end

    // ---------------------------------------------------------------------
    // Write back: saturating total and count, new entry, result word
    // ---------------------------------------------------------------------
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_upd;
    logic [COUNT_W-1:0] count_upd;
    logic [DIST_W-1:0]  step_sat;
    logic               first;

    always_comb
    begin
        first     = !rd_ent.valid;
        total_sum = {1'b0, rd_ent.running_distance} + (TOTAL_W + 1)'(calc_res.step);
        total_upd = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        count_upd = (&rd_ent.sighting_count) ? rd_ent.sighting_count
                                             : rd_ent.sighting_count + COUNT_W'(1);
        // the total uses the full step; only the reported step saturates
        step_sat  = (calc_res.step[ROOT_W-1:DIST_W] != '0) ? '1
                                                           : calc_res.step[DIST_W-1:0];

        new_ent.valid      = 1'b1;
        new_ent.last_x     = in_reg.pos_x;
        new_ent.last_y     = in_reg.pos_y;
        new_ent.last_frame = in_reg.frame_number;

        out_new.result_id  = in_reg.object_id;
        out_new.first_seen = first;

        if (first)
        begin
            new_ent.running_distance = '0;
            new_ent.sighting_count   = COUNT_W'(1);
            out_new.step_distance    = '0;
            out_new.speed            = '0;
        end
        else
        begin
            new_ent.running_distance = total_upd;
            new_ent.sighting_count   = count_upd;
            out_new.step_distance    = step_sat;
            out_new.speed            = calc_res.speed;
        end
        out_new.total_distance = new_ent.running_distance;
        out_new.sightings      = new_ent.sighting_count;
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tosd_pkg::T_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= tosd_pkg::FRAME_RATE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg   <= in_data;
            slot_reg <= slot_tab[in_data.object_id];
        end
        if (state_reg == tosd_pkg::T_PREP)
        begin
            req_reg <= prep_req;
        end
        if (load_out)
        begin
            out_data_reg <= out_new;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = slot_reg;
        ram_wdata  = new_ent;
        calc_start = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            tosd_pkg::T_CLEAR:
            begin
                // sweep the table, one empty entry per cycle
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_OBJECTS - 1))
                begin
                    state_next = tosd_pkg::T_IDLE;
                end
            end
            tosd_pkg::T_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = tosd_pkg::T_READ;
                end
            end
            tosd_pkg::T_READ:
            begin
                ram_re     = 1'b1;
                state_next = tosd_pkg::T_PREP;
            end
            tosd_pkg::T_PREP:
            begin
                // first sighting skips the arithmetic
                if (rd_ent.valid)
                begin
                    calc_start = 1'b1;
                    state_next = tosd_pkg::T_CALC;
                end
                else
                begin
                    state_next = tosd_pkg::T_WRITE;
                end
            end
            tosd_pkg::T_CALC:
            begin
                if (calc_done)
                begin
                    state_next = tosd_pkg::T_WRITE;
                end
            end
            tosd_pkg::T_WRITE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ram_we     = 1'b1;
                    load_out   = 1'b1;
                    state_next = tosd_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = tosd_pkg::T_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == tosd_pkg::T_READ))
        else $error("accepted word did not start a table read");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        calc_done |-> (state_reg == tosd_pkg::T_CALC))
        else $error("sequencer finished outside the wait state");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.first_seen) |->
            (out_data.step_distance == '0) && (out_data.speed == '0) &&
            (out_data.total_distance == '0) && (out_data.sightings == COUNT_W'(1)))
        else $error("first sighting carries nonzero motion");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sightings != '0))
        else $error("sighting count of zero delivered");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !load_out)
        else $error("result register reloaded while its word waits");

endmodule

[rtl/tosd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tosd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // hold read data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tosd_calc.sv]
// Arithmetic sequencer: squares, bit-pair square root, rate multiply, restoring divide.
// One shared subtract/compare unit and one multiplier; depends on tosd_pkg.
module tosd_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  tosd_pkg::calc_req_t           req,
    input  logic [tosd_pkg::RATE_W-1:0]   rate,
    output logic                          done,
    output tosd_pkg::calc_res_t           res
);

    localparam int RAD_W   = tosd_pkg::RAD_W;
    localparam int ROOT_W  = tosd_pkg::ROOT_W;
    localparam int MAG_W   = tosd_pkg::MAG_W;
    localparam int PROD_W  = tosd_pkg::PROD_W;
    localparam int SPEED_W = tosd_pkg::SPEED_W;
    localparam int NUM_W   = tosd_pkg::NUM_W;
    localparam int HEAD_W  = tosd_pkg::HEAD_W;
    localparam int CNT_W   = tosd_pkg::CNT_W;
    localparam int FRAME_W = tosd_pkg::FRAME_W;

    tosd_pkg::calc_state_t state_reg, state_next;

    logic [PROD_W-1:0]  prod_reg,  prod_next;
    logic [RAD_W-1:0]   rem_reg,   rem_next;
    logic [RAD_W-1:0]   root_reg,  root_next;
    logic [RAD_W-1:0]   bit_reg,   bit_next;
    logic [SPEED_W-1:0] num_reg,   num_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [ROOT_W-1:0]  step_reg,  step_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;

    // shared subtract/compare unit
    logic [RAD_W-1:0] alu_a, alu_b;
    logic [RAD_W:0]   alu_diff;
    logic             alu_ge;

    // shared multiplier
    logic [ROOT_W-1:0]       mul_a;
    logic [MAG_W-1:0]        mul_b;
    logic [ROOT_W+MAG_W-1:0] mul_p;

    logic [NUM_W-1:0] num_full;

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[RAD_W];
    assign mul_p    = mul_a * mul_b;
    assign num_full = prod_reg[tosd_pkg::RATE_FRAC_BITS +: NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tosd_pkg::C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        num_reg   <= num_next;
        cnt_reg   <= cnt_next;
        step_reg  <= step_next;
        speed_reg <= speed_next;
    end

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        speed_next = speed_reg;
        alu_a      = rem_reg;
        alu_b      = root_reg | bit_reg;
        mul_a      = ROOT_W'(req.dx_mag);
        mul_b      = req.dx_mag;

        unique case (state_reg)
            tosd_pkg::C_IDLE:
            begin
                if (start)
                begin
                    state_next = tosd_pkg::C_SQX;
                end
            end
            tosd_pkg::C_SQX:
            begin
                prod_next  = PROD_W'(mul_p);
                state_next = tosd_pkg::C_SQY;
            end
            tosd_pkg::C_SQY:
            begin
                mul_a      = ROOT_W'(req.dy_mag);
                mul_b      = req.dy_mag;
                rem_next   = RAD_W'(prod_reg);
                prod_next  = PROD_W'(mul_p);
                state_next = tosd_pkg::C_SUM;
            end
            tosd_pkg::C_SUM:
            begin
                rem_next   = rem_reg + RAD_W'(prod_reg);
                root_next  = '0;
                bit_next   = RAD_W'(1) << tosd_pkg::ROOT_TOP;
                state_next = tosd_pkg::C_ROOT;
            end
            tosd_pkg::C_ROOT:
            begin
                // root never has bits at or below bit, so OR is the add
                if (alu_ge)
                begin
                    rem_next  = alu_diff[RAD_W-1:0];
                    root_next = (root_reg >> 1) | bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    step_next = root_next[ROOT_W-1:0];
                    if (req.speed_en)
                    begin
                        state_next = tosd_pkg::C_MUL;
                    end
                    else
                    begin
                        speed_next = '0;
                        state_next = tosd_pkg::C_DONE;
                    end
                end
            end
            tosd_pkg::C_MUL:
            begin
                mul_a      = step_reg;
                mul_b      = MAG_W'(rate);
                prod_next  = PROD_W'(mul_p);
                state_next = tosd_pkg::C_SAT;
            end
            tosd_pkg::C_SAT:
            begin
                // quotient overflows the speed field exactly when head >= delta
                alu_a = RAD_W'(num_full[NUM_W-1 -: HEAD_W]);
                alu_b = RAD_W'(req.delta);
                if (alu_ge)
                begin
                    speed_next = '1;
                    state_next = tosd_pkg::C_DONE;
                end
                else
                begin
                    rem_next   = alu_a;
                    num_next   = num_full[SPEED_W-1:0];
                    root_next  = '0;
                    cnt_next   = CNT_W'(SPEED_W - 1);
                    state_next = tosd_pkg::C_DIV;
                end
            end
            tosd_pkg::C_DIV:
            begin
                alu_a     = RAD_W'({rem_reg[FRAME_W-1:0], num_reg[SPEED_W-1]});
                alu_b     = RAD_W'(req.delta);
                rem_next  = alu_ge ? alu_diff[RAD_W-1:0] : alu_a;
                root_next = {root_reg[RAD_W-2:0], alu_ge};
                num_next  = num_reg << 1;
                if (cnt_reg == '0)
                begin
                    speed_next = root_next[SPEED_W-1:0];
                    state_next = tosd_pkg::C_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            tosd_pkg::C_DONE:
            begin
                state_next = tosd_pkg::C_IDLE;
            end
            default:
            begin
                state_next = tosd_pkg::C_IDLE;
            end
        endcase
    end

    assign done      = (state_reg == tosd_pkg::C_DONE);
    assign res.step  = step_reg;
    assign res.speed = speed_reg;

endmodule

[verif/tracked_object_speed_distance_core_tb.sv]
// Self-checking testbench for tracked_object_speed_distance_core.
// Holds its own per-object track model and checks every result word against it.
// Depends on tosd_pkg and the core RTL only.
module tracked_object_speed_distance_core_tb;

    localparam int ID_W                = tosd_pkg::ID_W;
    localparam int FRAME_W             = tosd_pkg::FRAME_W;
    localparam int POS_W               = tosd_pkg::POS_W;
    localparam int DIST_W              = tosd_pkg::DIST_W;
    localparam int SPEED_W             = tosd_pkg::SPEED_W;
    localparam int TOTAL_W             = tosd_pkg::TOTAL_W;
    localparam int COUNT_W             = tosd_pkg::COUNT_W;
    localparam int RATE_W              = tosd_pkg::RATE_W;
    localparam int ROOT_W              = tosd_pkg::ROOT_W;
    localparam int RATE_FRAC_BITS      = tosd_pkg::RATE_FRAC_BITS;
    localparam int MAX_OBJECTS_DEFAULT = tosd_pkg::MAX_OBJECTS_DEFAULT;
    localparam logic [RATE_W-1:0] FRAME_RATE_RESET = tosd_pkg::FRAME_RATE_RESET;

    // Longest run of cycles with no word moving on either channel before the run is
    // called hung.
    localparam int STALL_LIMIT = 4000;
    // Cycles to let pass after the last result before the verdict.
    localparam int TAIL_CYCLES = 80;
    localparam int POS_MAX     = 524287;
    localparam int POS_MIN     = -524288;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [RATE_W-1:0] cfg_data = '0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    tosd_pkg::in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    tosd_pkg::out_item_t out_data;

    tracked_object_speed_distance_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Track model state: one entry per object id, plus the frame rate register.
    bit                      seen      [MAX_OBJECTS_DEFAULT];
    logic signed [POS_W-1:0] last_px   [MAX_OBJECTS_DEFAULT];
    logic signed [POS_W-1:0] last_py   [MAX_OBJECTS_DEFAULT];
    logic [FRAME_W-1:0]      last_frm  [MAX_OBJECTS_DEFAULT];
    logic [TOTAL_W-1:0]      dist_sum  [MAX_OBJECTS_DEFAULT];
    logic [COUNT_W-1:0]      sight_cnt [MAX_OBJECTS_DEFAULT];
    logic [RATE_W-1:0]       rate_model = FRAME_RATE_RESET;

    // Result words predicted for accepted sightings, oldest first.
    tosd_pkg::out_item_t pending_tracks[$];
    int         error_count = 0;
    idle_mode_t idle_mode   = IDLE_NONE;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Percent of cycles in which the sender holds off or the receiver stalls.
    function automatic int idle_pct(bit for_sender);
        case (idle_mode)
            IDLE_SEND: return for_sender ? 45 : 0;
            IDLE_RECV: return for_sender ? 0 : 45;
            IDLE_BOTH: return 7;
            default:   return 0;
        endcase
    endfunction

    // Floor square root, one result bit at a time from the top.
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = ROOT_W; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= n)
                root = cand;
        end
        return root;
    endfunction

    // Advance the track of one object by one sighting and return the word it gives.
    function automatic tosd_pkg::out_item_t track_sighting(tosd_pkg::in_item_t w);
        tosd_pkg::out_item_t r;
        int unsigned     slot;
        longint          dx;
        longint          dy;
        longint unsigned step;
        longint unsigned spd;
        longint unsigned sum;
        longint unsigned delta;
        slot = w.object_id % MAX_OBJECTS_DEFAULT;
        r = '0;
        r.result_id = w.object_id;
        if (!seen[slot])
        begin
            r.first_seen    = 1'b1;
            dist_sum[slot]  = '0;
            sight_cnt[slot] = 1;
            seen[slot]      = 1'b1;
        end
        else
        begin
            dx   = longint'($signed(w.pos_x)) - longint'(last_px[slot]);
            dy   = longint'($signed(w.pos_y)) - longint'(last_py[slot]);
            step = floor_root(longint'(dx * dx) + longint'(dy * dy));
            spd  = 0;
            // Speed only when the frame moved forward; a zero rate gives zero.
            if (w.frame_number > last_frm[slot])
            begin
                delta = w.frame_number - last_frm[slot];
                spd   = (step * rate_model) / (delta << RATE_FRAC_BITS);
                if (spd > 64'hFF_FFFF)
                    spd = 64'hFF_FFFF;
            end
            // Total takes the unsaturated step; only the step field clips.
            sum = dist_sum[slot] + step;
            dist_sum[slot] = (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
            if (sight_cnt[slot] != '1)
                sight_cnt[slot]++;
            r.step_distance = (step > 64'hF_FFFF) ? '1 : step[DIST_W-1:0];
            r.speed         = spd[SPEED_W-1:0];
        end
        r.total_distance = dist_sum[slot];
        r.sightings      = sight_cnt[slot];
        last_px[slot]    = w.pos_x;
        last_py[slot]    = w.pos_y;
        last_frm[slot]   = w.frame_number;
        return r;
    endfunction

    task automatic compare_field(string name, int unsigned id, longint unsigned got,
                                 longint unsigned want);
        if (got != want)
            report_error($sformatf("id %0d %s: got %0d, expected %0d", id, name, got, want));
    endtask

    task automatic check_word(tosd_pkg::out_item_t got);
        tosd_pkg::out_item_t want;
        if (pending_tracks.size() == 0)
        begin
            report_error($sformatf("result word for id %0d with none expected", got.result_id));
            return;
        end
        want = pending_tracks.pop_front();
        compare_field("result_id", want.result_id, got.result_id, want.result_id);
        compare_field("first_seen", want.result_id, got.first_seen, want.first_seen);
        compare_field("step_distance", want.result_id, got.step_distance, want.step_distance);
        compare_field("speed", want.result_id, got.speed, want.speed);
        compare_field("total_distance", want.result_id, got.total_distance,
                      want.total_distance);
        compare_field("sightings", want.result_id, got.sightings, want.sightings);
    endtask

    // Present one word, hold it until accepted, then record its expected result.
    // Valid is left high on return so a following word can go out back to back;
    // anything that lets time pass without a word lowers it first.
    task automatic send_word(tosd_pkg::in_item_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct(1'b1))
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_tracks = {pending_tracks, track_sighting(w)};
    endtask

    task automatic send_sighting(int id, logic [FRAME_W-1:0] frame, int x, int y);
        tosd_pkg::in_item_t w;
        w.object_id    = id[ID_W-1:0];
        w.frame_number = frame;
        w.pos_x        = x[POS_W-1:0];
        w.pos_y        = y[POS_W-1:0];
        send_word(w);
    endtask

    // Drop valid and hold until every expected word is back and the core takes input.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tracks.size() != 0 || !in_ready)
            @(posedge clk);
    endtask

    task automatic set_frame_rate(logic [RATE_W-1:0] value);
        wait_until_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        rate_model  = value;
    endtask

    function automatic logic signed [POS_W-1:0] clamp_pos(int v);
        if (v > POS_MAX)
            return POS_MAX[POS_W-1:0];
        if (v < POS_MIN)
            return POS_MIN[POS_W-1:0];
        return v[POS_W-1:0];
    endfunction

    // Mostly plausible tracks on a small set of ids (frames advancing, modest
    // moves, now and then a big jump or a repeated frame); the rest is noise.
    function automatic tosd_pkg::in_item_t make_track_word();
        tosd_pkg::in_item_t w;
        int       pick;
        int       id;
        int       reach;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            w.object_id    = ID_W'($urandom);
            w.frame_number = $urandom;
            w.pos_x        = POS_W'($urandom);
            w.pos_y        = POS_W'($urandom);
            return w;
        end
        id = (pick < 32) ? $urandom_range(0, 255) : $urandom_range(0, 23);
        w.object_id = id[ID_W-1:0];
        if (!seen[id])
        begin
            w.frame_number = $urandom_range(0, 100000);
            w.pos_x = clamp_pos(int'($urandom_range(0, 40000)) - 20000);
            w.pos_y = clamp_pos(int'($urandom_range(0, 40000)) - 20000);
            return w;
        end
        case ($urandom_range(9))
            0:       reach = 300000;
            1, 2:    reach = 5000;
            default: reach = 300;
        endcase
        w.pos_x = clamp_pos(int'(last_px[id]) + int'($urandom_range(0, 2 * reach)) - reach);
        w.pos_y = clamp_pos(int'(last_py[id]) + int'($urandom_range(0, 2 * reach)) - reach);
        w.frame_number = last_frm[id] + (($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6));
        return w;
    endfunction

    // First sightings at the id, frame and position extremes, default frame rate.
    task automatic test_first_sighting();
        send_sighting(0, 32'd0, POS_MIN, POS_MAX);
        send_sighting(255, 32'hFFFF_FFFF, POS_MAX, POS_MIN);
        send_sighting(128, 32'd1000, 0, 0);
    endtask

    // Later sightings: largest step (step field and speed clip), no move, small moves.
    task automatic test_step_and_speed();
        send_sighting(0, 32'd1, POS_MAX, POS_MIN);
        send_sighting(0, 32'd3, POS_MAX, POS_MIN);
        send_sighting(0, 32'd7, POS_MAX - 300, POS_MIN + 400);
        send_sighting(128, 32'd1001, 3, 4);
        send_sighting(128, 32'd1003, 3, -7);
    endtask

    // Frame equal to, before, and wrapped behind the stored one: zero speed; then a later frame.
    task automatic test_frame_not_later();
        send_sighting(128, 32'd1003, 40, -7);
        send_sighting(128, 32'd10, 90, 60);
        send_sighting(255, 32'd0, POS_MIN, POS_MAX);
        send_sighting(255, 32'd5, POS_MIN + 1000, POS_MAX);
    endtask

    // Zero and largest frame rates, one frame per second, and the top of the working range.
    task automatic test_frame_rate_extremes();
        set_frame_rate('0);
        send_sighting(128, 32'd20, 100, 0);
        set_frame_rate('1);
        send_sighting(128, 32'd21, 200, 0);
        send_sighting(0, 32'd8, POS_MIN, POS_MAX);
        set_frame_rate(16'd256);
        send_sighting(128, 32'd22, 1000, 0);
        set_frame_rate(16'd61440);
        send_sighting(128, 32'd30, 1000, 25000);
        send_sighting(0, 32'd9, POS_MAX, POS_MAX);
    endtask

    // Random tracks, one idle pattern and frame rate per phase; drain midway in each phase.
    task automatic test_random_tracks();
        idle_mode_t modes [6];
        logic [RATE_W-1:0] rates [6];
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};
        rates = '{FRAME_RATE_RESET, 16'd256, 16'd61440, 16'hFFFF,
                  RATE_W'($urandom_range(256, 61440)), RATE_W'($urandom)};
        for (int p = 0; p < 6; p++)
        begin
            set_frame_rate(rates[p]);
            idle_mode = modes[p];
            for (int i = 0; i < 310; i++)
            begin
                if (i == 155)
                    wait_until_idle();
                send_word(make_track_word());
            end
        end
    endtask

    // Take result words and check them; drive out_ready for the next cycle.
    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_word(out_data);
            out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // End the run if no word moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tracked_object_speed_distance_core_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // Hold until the clearing pass is over before the first word.
        wait_until_idle();
        test_first_sighting();
        test_step_and_speed();
        test_frame_not_later();
        test_frame_rate_extremes();
        test_random_tracks();
        wait_until_idle();
        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tracked_object_speed_distance_core_tb: done, clean");
        else
            $display("tracked_object_speed_distance_core_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/tosd_pkg.sv
rtl/tosd_ram.sv
rtl/tosd_calc.sv
rtl/tracked_object_speed_distance_core.sv
verif/tracked_object_speed_distance_core_tb.sv
